FILE: hdl/l11enc_pkg.sv
package l11enc_pkg;

  // Item field widths.
  localparam int unsigned VALUE_W = 20;
  localparam int unsigned MAG_W   = 20;
  localparam int unsigned DIV_W   = 16;
  localparam int unsigned WORD_W  = 16;

  // Fixed-point scaling of the quotient.
  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned NUM_W     = MAG_W + FRAC_BITS;

  // Divider pipeline shape: quotient bits retired per stage and stage count.
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = NUM_W / DIV_STEPS;

  // Normalization limits and range.
  localparam int unsigned CMP_W      = 48;
  localparam int unsigned EXP_MAX    = 15;
  localparam logic [CMP_W-1:0] HIGH_LIMIT = 48'd4190208;  // 1023 << 12
  localparam logic [CMP_W-1:0] LOW_LIMIT  = 48'd2093056;  // 511 << 12

  // Fixed result words.
  localparam logic [WORD_W-1:0] WORD_ZERO      = 16'h0000;
  localparam logic [WORD_W-1:0] WORD_SATURATED = 16'h7BFF;
  localparam logic [DIV_W-1:0]  DIV_ALL_ONES   = 16'hFFFF;

  // Per-item control that travels alongside the arithmetic payload.
  typedef struct packed {
    logic valid;
    logic neg;
    logic zero;
    logic sat;
  } l11_side_t;

  // Halving k times (rounding up) still leaves the value at or above the
  // high limit exactly when the value exceeds (HIGH_LIMIT - 1) << k.
  function automatic logic [CMP_W-1:0] up_limit(input int unsigned k);
    logic [CMP_W-1:0] base;
    base = HIGH_LIMIT - 48'd1;
    return base << k;
  endfunction

  // Doubling k times still leaves the value below the low limit exactly
  // when the value is below ceil(LOW_LIMIT / 2^k).
  function automatic logic [CMP_W-1:0] down_limit(input int unsigned k);
    logic [CMP_W-1:0] bias;
    bias = (48'd1 << k) - 48'd1;
    return (LOW_LIMIT + bias) >> k;
  endfunction

endpackage

FILE: hdl/l11enc_div_stage.sv
module l11enc_div_stage (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic [l11enc_pkg::DIV_W-1:0]       divisor,
  input  l11enc_pkg::l11_side_t              side_i,
  input  logic [l11enc_pkg::DIV_W-1:0]       rem_i,
  input  logic [l11enc_pkg::NUM_W-1:0]       num_i,
  input  logic [l11enc_pkg::NUM_W-1:0]       quot_i,
  output l11enc_pkg::l11_side_t              side_o,
  output logic [l11enc_pkg::DIV_W-1:0]       rem_o,
  output logic [l11enc_pkg::NUM_W-1:0]       num_o,
  output logic [l11enc_pkg::NUM_W-1:0]       quot_o
);

  l11enc_pkg::l11_side_t               side_r;
  logic [l11enc_pkg::DIV_W-1:0]        rem_r, rem_nxt;
  logic [l11enc_pkg::NUM_W-1:0]        num_r, num_nxt;
  logic [l11enc_pkg::NUM_W-1:0]        quot_r, quot_nxt;

  // Restoring division: each step brings down one numerator bit and
  // retires one quotient bit.
  always_comb begin
    logic [l11enc_pkg::DIV_W:0] trial;
    logic                       qbit;
    rem_nxt  = rem_i;
    num_nxt  = num_i;
    quot_nxt = quot_i;
    for (int s = 0; s < int'(l11enc_pkg::DIV_STEPS); s++) begin
      trial = {rem_nxt, num_nxt[l11enc_pkg::NUM_W-1]};
      qbit  = (trial >= {1'b0, divisor});
      if (qbit) begin
        rem_nxt = l11enc_pkg::DIV_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[l11enc_pkg::DIV_W-1:0];
      end
      num_nxt  = {num_nxt[l11enc_pkg::NUM_W-2:0], 1'b0};
      quot_nxt = {quot_nxt[l11enc_pkg::NUM_W-2:0], qbit};
    end
  end

  // Control bits are reset; the arithmetic payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (adv) begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r  <= rem_nxt;
      num_r  <= num_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign side_o = side_r;
  assign rem_o  = rem_r;
  assign num_o  = num_r;
  assign quot_o = quot_r;

endmodule

FILE: hdl/l11enc_norm.sv
module l11enc_norm (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  l11enc_pkg::l11_side_t              side_i,
  input  logic [l11enc_pkg::NUM_W-1:0]       quot_i,
  output l11enc_pkg::l11_side_t              side_o,
  output logic [l11enc_pkg::WORD_W-1:0]      word_o
);

  localparam int unsigned SH_W = $clog2(l11enc_pkg::EXP_MAX + 1);

  l11enc_pkg::l11_side_t               side1_r;
  logic [l11enc_pkg::NUM_W-1:0]        val1_r;
  logic [SH_W-1:0]                     up1_r, up_nxt;
  logic [SH_W-1:0]                     dn1_r, dn_nxt;

  l11enc_pkg::l11_side_t               side2_r;
  logic [l11enc_pkg::WORD_W-1:0]       word2_r, word_nxt;

  // First stage: count how many halvings or doublings the value needs.
  // Both flag rows are thermometer codes, so their population counts are
  // the shift amounts.
  always_comb begin
    logic [l11enc_pkg::EXP_MAX-1:0] up_flags;
    logic [l11enc_pkg::EXP_MAX-1:0] dn_flags;
    logic [l11enc_pkg::CMP_W-1:0]   vwide;
    vwide = l11enc_pkg::CMP_W'(quot_i);
    for (int k = 0; k < int'(l11enc_pkg::EXP_MAX); k++) begin
      up_flags[k] = (vwide > l11enc_pkg::up_limit(k));
      dn_flags[k] = (vwide < l11enc_pkg::down_limit(k));
    end
    up_nxt = SH_W'($countones(up_flags));
    dn_nxt = SH_W'($countones(dn_flags));
  end

  // Second stage: apply the shift, take the mantissa and pack the word.
  always_comb begin
    logic [l11enc_pkg::NUM_W:0]      rounded;
    logic [l11enc_pkg::CMP_W-1:0]    scaled;
    logic [9:0]                      mag;
    logic [10:0]                     mant;
    logic [4:0]                      expo;
    rounded = ({1'b0, val1_r} + ((33'd1 << up1_r) - 33'd1)) >> up1_r;
    scaled  = l11enc_pkg::CMP_W'(val1_r) << dn1_r;
    if (up1_r != '0) begin
      mag = rounded[l11enc_pkg::FRAC_BITS +: 10];
    end else begin
      mag = scaled[l11enc_pkg::FRAC_BITS +: 10];
    end
    if (side1_r.neg) begin
      mant = 11'(11'd0 - {1'b0, mag});
    end else begin
      mant = {1'b0, mag};
    end
    expo = 5'({1'b0, up1_r} - {1'b0, dn1_r});
    priority if (side1_r.zero) begin
      word_nxt = l11enc_pkg::WORD_ZERO;
    end else if (side1_r.sat) begin
      word_nxt = l11enc_pkg::WORD_SATURATED;
    end else begin
      word_nxt = {expo, mant};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r <= '0;
      side2_r <= '0;
    end else if (adv) begin
      side1_r <= side_i;
      side2_r <= side1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val1_r  <= quot_i;
      up1_r   <= up_nxt;
      dn1_r   <= dn_nxt;
      word2_r <= word_nxt;
    end
  end

  assign side_o = side2_r;
  assign word_o = word2_r;

endmodule

FILE: hdl/scaled_int_to_pmbus_linear11_unit.sv
// Scaled integer to PMBus LINEAR11 encoder.
//
// Input channel: in_valid / in_stall with in_value, a signed quantity in units
// of 1/k. Result channel: out_valid / out_stall with out_linear_word, the
// 16-bit LINEAR11 word (5-bit exponent over 11-bit mantissa). A transfer takes
// place on a clock edge where valid is high and stall is low.
// The divisor k is written through cfg_wr_en / cfg_wr_data; write it only
// while no item is in flight.
//
// The input transfer edge loads the entry stage; eight divider stages retiring
// four quotient bits each and two normalization stages follow, the last of
// which is the output register. Throughput is one item per clock while the
// receiver does not stall. When out_stall holds a valid result, the whole
// pipeline freezes and in_stall rises in the same cycle; nothing is dropped
// or repeated. Reset (rst_n low, synchronous) empties the pipeline and sets
// k to 1.
module scaled_int_to_pmbus_linear11_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [l11enc_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [l11enc_pkg::WORD_W-1:0]       out_linear_word,
  input  logic                                cfg_wr_en,
  input  logic [l11enc_pkg::DIV_W-1:0]        cfg_wr_data
);

  localparam int unsigned NST = l11enc_pkg::DIV_STAGES;

  logic                                 adv;
  logic [l11enc_pkg::DIV_W-1:0]         divisor_r;

  l11enc_pkg::l11_side_t                side_c [NST+1];
  logic [l11enc_pkg::DIV_W-1:0]         rem_c  [NST+1];
  logic [l11enc_pkg::NUM_W-1:0]         num_c  [NST+1];
  logic [l11enc_pkg::NUM_W-1:0]         quot_c [NST+1];

  l11enc_pkg::l11_side_t                ent_side_r, ent_side_nxt;
  logic [l11enc_pkg::NUM_W-1:0]         ent_num_r, ent_num_nxt;

  l11enc_pkg::l11_side_t                fin_side;

  // The pipeline moves unless a finished result is held by the receiver.
  assign adv      = !(fin_side.valid && out_stall);
  assign in_stall = !adv;

  // Divisor register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r <= l11enc_pkg::DIV_W'(1);
    end else if (cfg_wr_en) begin
      divisor_r <= cfg_wr_data;
    end
  end

  // Entry stage: sign, magnitude and the special-case flags.
  always_comb begin
    logic [l11enc_pkg::MAG_W-1:0] mag;
    if (in_value[l11enc_pkg::VALUE_W-1]) begin
      mag = l11enc_pkg::MAG_W'(-in_value);
    end else begin
      mag = l11enc_pkg::MAG_W'(in_value);
    end
    ent_side_nxt.valid = in_valid;
    ent_side_nxt.neg   = in_value[l11enc_pkg::VALUE_W-1];
    ent_side_nxt.zero  = (in_value == '0);
    ent_side_nxt.sat   = (divisor_r == '0) || (divisor_r == l11enc_pkg::DIV_ALL_ONES);
    ent_num_nxt        = {mag, {l11enc_pkg::FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_side_r <= '0;
    end else if (adv) begin
      ent_side_r <= ent_side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ent_num_r <= ent_num_nxt;
    end
  end

  assign side_c[0] = ent_side_r;
  assign rem_c[0]  = '0;
  assign num_c[0]  = ent_num_r;
  assign quot_c[0] = '0;

  // Divider chain.
  for (genvar g = 0; g < NST; g++) begin : g_div
    l11enc_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .divisor (divisor_r),
      .side_i  (side_c[g]),
      .rem_i   (rem_c[g]),
      .num_i   (num_c[g]),
      .quot_i  (quot_c[g]),
      .side_o  (side_c[g+1]),
      .rem_o   (rem_c[g+1]),
      .num_o   (num_c[g+1]),
      .quot_o  (quot_c[g+1])
    );
  end

  // Normalization and packing; its last register drives the result channel.
  l11enc_norm u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .side_i (side_c[NST]),
    .quot_i (quot_c[NST]),
    .side_o (fin_side),
    .word_o (out_linear_word)
  );

  assign out_valid = fin_side.valid;

  // The exponent never reaches -16: normalization stops at -15.
  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_linear_word[15:11] != 5'b10000))
    else $error("exponent field out of range");

  // An item in the entry stage reaches the first divider stage on advance.
  a_entry_moves: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (side_c[1].valid == $past(ent_side_r.valid)))
    else $error("entry stage valid lost on advance");

  // A frozen pipeline keeps its entry stage.
  a_entry_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(ent_side_r.valid))
    else $error("entry stage changed while frozen");

endmodule
